FILE: rtl/csdq_pkg.sv
package csdq_pkg;

    // store geometry
    localparam int DEPTH  = 64;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int HB_W   = $clog2(DEPTH) + 16;
    localparam int OCC_W  = 22;
    localparam int BL_W   = 23;
    localparam int CMP_W  = (HB_W + 1 > BL_W) ? HB_W + 1 : BL_W;
    localparam int LIM_W  = ((CW > 7) ? CW : 7) + 1;
    localparam logic [OCC_W-1:0] OCC_MAX = '1;

    // class codes
    localparam logic [1:0] CLS_TCP   = 2'd0;
    localparam logic [1:0] CLS_UDP   = 2'd1;
    localparam logic [1:0] CLS_VOICE = 2'd2;

    // ports that pick a class
    localparam logic [15:0] PORT_FTP_DATA = 16'd20;
    localparam logic [15:0] PORT_FTP_CTRL = 16'd21;
    localparam logic [15:0] PORT_DNS      = 16'd53;

    // result status codes
    localparam logic [2:0] ST_ENQ      = 3'd0;
    localparam logic [2:0] ST_ENQ_DROP = 3'd1;
    localparam logic [2:0] ST_IN_DROP  = 3'd2;
    localparam logic [2:0] ST_DEQ      = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    // operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_QUEUE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_COUNT_BYTES = 2'd1;
    localparam logic [1:0] CFG_MEAN_BYTES  = 2'd2;
    localparam logic [1:0] CFG_MAX_AGE     = 2'd3;

    typedef struct packed {
        logic        op;
        logic [15:0] pkt_tag;
        logic [15:0] dest_port;
        logic [15:0] pkt_bytes;
        logic [31:0] pkt_time_ms;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_tag;
        logic [1:0]  out_class;
        logic [15:0] out_bytes;
        logic [6:0]  queue_count;
    } t_out;

    typedef struct packed {
        logic [15:0] tag;
        logic [1:0]  cls;
        logic [15:0] bytes;
        logic [31:0] ptime;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

FILE: rtl/csdq_ram.sv
module csdq_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/class_aware_selective_drop_queue.sv
// one item at a time; a plain enqueue, a full-store drop or an empty dequeue goes
// straight to S_DONE and then to the output register, which waits on a busy output
// a dequeue compacts the store one entry per cycle before its result is loaded
// an at-limit enqueue also scans one entry per cycle and compacts after a drop, both
// paced by the single read port of the descriptor store
// synchronous active-low reset empties the queue, clears occupancy, loads defaults
module class_aware_selective_drop_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  csdq_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output csdq_pkg::t_out  o_out,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CRED   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_DEBIT  = 7'b0010000,
        S_SHIFT  = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    typedef enum logic [1:0] {
        M_HEAD,
        M_VOICE,
        M_WANT
    } t_mode;

    t_state r_state;
    t_mode  r_mode;

    // configuration
    logic [6:0]  r_queue_limit;
    logic        r_count_bytes;
    logic [15:0] r_mean_bytes;
    logic [31:0] r_max_age;

    // queue bookkeeping
    logic [csdq_pkg::CW-1:0]    r_count;
    logic [csdq_pkg::HB_W-1:0]  r_held_bytes;
    logic [csdq_pkg::OCC_W-1:0] r_occ [3];

    // latched item
    csdq_pkg::t_entry r_inc;
    logic [31:0]      r_now;

    // scan and shift control
    logic [csdq_pkg::CW-1:0] r_ptr;
    logic                    r_pend;
    logic [csdq_pkg::AW-1:0] r_pidx;
    logic                    r_found;
    logic [1:0]              r_want;
    logic [csdq_pkg::AW-1:0] r_sel;
    csdq_pkg::t_entry        r_sel_ent;

    // result
    logic [2:0]       r_res_status;
    csdq_pkg::t_entry r_res_ent;
    logic             r_dec;
    logic             r_out_valid;
    csdq_pkg::t_out   r_out;

    // store ports
    logic                          ram_we;
    logic [csdq_pkg::AW-1:0]       ram_waddr;
    logic [csdq_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [csdq_pkg::AW-1:0]       ram_raddr;
    logic [csdq_pkg::ENTRY_W-1:0]  ram_rdata;
    csdq_pkg::t_entry              rd_ent;

    csdq_ram #(
        .W (csdq_pkg::ENTRY_W),
        .D (csdq_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_ent = csdq_pkg::t_entry'(ram_rdata);

    // classify the incoming item
    logic [1:0] in_cls;
    always_comb begin
        if (i_in.dest_port == csdq_pkg::PORT_FTP_DATA ||
            i_in.dest_port == csdq_pkg::PORT_FTP_CTRL) begin
            in_cls = csdq_pkg::CLS_TCP;
        end else if (i_in.dest_port == csdq_pkg::PORT_DNS) begin
            in_cls = csdq_pkg::CLS_UDP;
        end else begin
            in_cls = csdq_pkg::CLS_VOICE;
        end
    end

    logic accept;
    logic full;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count >= csdq_pkg::CW'(csdq_pkg::DEPTH));

    // limit test
    logic [csdq_pkg::BL_W-1:0]  byte_limit;
    logic [csdq_pkg::CMP_W-1:0] byte_sum;
    logic                       at_limit;
    assign byte_limit = csdq_pkg::BL_W'(r_queue_limit) * csdq_pkg::BL_W'(r_mean_bytes);
    assign byte_sum   = csdq_pkg::CMP_W'(r_held_bytes) + csdq_pkg::CMP_W'(i_in.pkt_bytes);
    always_comb begin
        if (r_count_bytes) begin
            at_limit = byte_sum >= csdq_pkg::CMP_W'(byte_limit);
        end else begin
            at_limit = (csdq_pkg::LIM_W'(r_count) + csdq_pkg::LIM_W'(1)) >=
                       csdq_pkg::LIM_W'(r_queue_limit);
        end
    end

    // scan and shift read issue
    logic issue;
    assign issue = (r_state == S_SCAN || r_state == S_SHIFT) && (r_ptr < r_count);

    // age test on the entry read back
    logic [32:0] age_diff;
    logic        age_bad;
    logic        rd_voice;
    logic        rd_last;
    assign age_diff = {1'b0, r_now} - {1'b0, rd_ent.ptime};
    assign age_bad  = !age_diff[32] && (age_diff[31:0] > r_max_age);
    assign rd_voice = (rd_ent.cls == csdq_pkg::CLS_VOICE);
    assign rd_last  = (csdq_pkg::CW'(r_pidx) + csdq_pkg::CW'(1)) == r_count;

    // store port steering
    always_comb begin
        ram_raddr = r_ptr[csdq_pkg::AW-1:0];
        if (r_state == S_SHIFT) begin
            ram_we    = r_pend;
            ram_waddr = r_pidx - csdq_pkg::AW'(1);
            ram_wdata = ram_rdata;
        end else begin
            ram_we    = accept && (i_in.op == csdq_pkg::OP_ENQ) && !full;
            ram_waddr = r_count[csdq_pkg::AW-1:0];
            ram_wdata = {i_in.pkt_tag, in_cls, i_in.pkt_bytes, i_in.pkt_time_ms};
        end
    end

    // occupancy of the selected classes
    logic [csdq_pkg::OCC_W-1:0] inc_occ;
    logic [csdq_pkg::OCC_W-1:0] sel_occ;
    logic [csdq_pkg::OCC_W:0]   cred_sum;
    logic [csdq_pkg::OCC_W-1:0] cred_val;
    logic [csdq_pkg::OCC_W-1:0] deb_val;
    logic [csdq_pkg::OCC_W-1:0] sel_b;
    always_comb begin
        inc_occ = '0;
        sel_occ = '0;
        for (int k = 0; k < 3; k++) begin
            if (r_inc.cls == 2'(k)) inc_occ = r_occ[k];
            if (r_sel_ent.cls == 2'(k)) sel_occ = r_occ[k];
        end
        cred_sum = {1'b0, inc_occ} + (csdq_pkg::OCC_W + 1)'(r_inc.bytes);
        cred_val = cred_sum[csdq_pkg::OCC_W] ? csdq_pkg::OCC_MAX
                                             : cred_sum[csdq_pkg::OCC_W-1:0];
        sel_b    = csdq_pkg::OCC_W'(r_sel_ent.bytes);
        deb_val  = (sel_occ > sel_b) ? sel_occ - sel_b : '0;
    end

    logic voice_big;
    assign voice_big = (r_occ[2] > r_occ[0]) && (r_occ[2] > r_occ[1]);

    logic [csdq_pkg::CW-1:0] final_count;
    assign final_count = r_count - csdq_pkg::CW'(r_dec);

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_mode        <= M_HEAD;
            r_queue_limit <= 7'd50;
            r_count_bytes <= 1'b0;
            r_mean_bytes  <= 16'd500;
            r_max_age     <= 32'd300;
            r_count       <= '0;
            r_held_bytes  <= '0;
            for (int k = 0; k < 3; k++) r_occ[k] <= '0;
            r_pend        <= 1'b0;
            r_found       <= 1'b0;
            r_dec         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    csdq_pkg::CFG_QUEUE_LIMIT: r_queue_limit <= i_cfg_data[6:0];
                    csdq_pkg::CFG_COUNT_BYTES: r_count_bytes <= i_cfg_data[0];
                    csdq_pkg::CFG_MEAN_BYTES:  r_mean_bytes  <= i_cfg_data[15:0];
                    csdq_pkg::CFG_MAX_AGE:     r_max_age     <= i_cfg_data;
                    default: ;
                endcase
            end

            // result taken while no new one is being loaded
            if (r_out_valid && i_out_ready && r_state != S_DONE) r_out_valid <= 1'b0;

            // pipelined read bookkeeping
            r_pend <= issue;
            r_pidx <= r_ptr[csdq_pkg::AW-1:0];
            if (issue) r_ptr <= r_ptr + csdq_pkg::CW'(1);

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_inc   <= '{tag: i_in.pkt_tag, cls: in_cls,
                                     bytes: i_in.pkt_bytes, ptime: i_in.pkt_time_ms};
                        r_now   <= i_in.now_ms;
                        r_ptr   <= '0;
                        r_found <= 1'b0;
                        r_dec   <= 1'b0;
                        if (i_in.op == csdq_pkg::OP_DEQ) begin
                            if (r_count == '0) begin
                                r_res_status <= csdq_pkg::ST_EMPTY;
                                r_res_ent    <= '0;
                                r_state      <= S_DONE;
                            end else begin
                                r_mode  <= M_HEAD;
                                r_state <= S_SCAN;
                            end
                        end else if (full) begin
                            r_res_status <= csdq_pkg::ST_IN_DROP;
                            r_res_ent    <= '{tag: i_in.pkt_tag, cls: in_cls,
                                              bytes: i_in.pkt_bytes, ptime: '0};
                            r_state      <= S_DONE;
                        end else begin
                            r_count      <= r_count + csdq_pkg::CW'(1);
                            r_held_bytes <= r_held_bytes + csdq_pkg::HB_W'(i_in.pkt_bytes);
                            if (at_limit) begin
                                r_state <= S_CRED;
                            end else begin
                                r_res_status <= csdq_pkg::ST_ENQ;
                                r_res_ent    <= '0;
                                r_state      <= S_DONE;
                            end
                        end
                    end
                end
                S_CRED: begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_inc.cls == 2'(k)) r_occ[k] <= cred_val;
                    end
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_ptr   <= '0;
                    r_found <= 1'b0;
                    if (voice_big && r_inc.cls != csdq_pkg::CLS_VOICE) begin
                        // the incoming item itself goes
                        r_mode    <= M_VOICE;
                        r_sel     <= csdq_pkg::AW'(r_count - csdq_pkg::CW'(1));
                        r_sel_ent <= r_inc;
                        r_state   <= S_DEBIT;
                    end else if (voice_big) begin
                        r_mode  <= M_VOICE;
                        r_state <= S_SCAN;
                    end else begin
                        r_mode  <= M_WANT;
                        r_want  <= (r_occ[0] > r_occ[1]) ? csdq_pkg::CLS_TCP
                                                         : csdq_pkg::CLS_UDP;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_pend) begin
                        case (r_mode)
                            M_HEAD: begin
                                r_sel     <= r_pidx;
                                r_sel_ent <= rd_ent;
                                r_state   <= S_DEBIT;
                            end
                            M_WANT: begin
                                if (rd_ent.cls == r_want) begin
                                    r_sel     <= r_pidx;
                                    r_sel_ent <= rd_ent;
                                    r_state   <= S_DEBIT;
                                end else if (rd_last) begin
                                    r_res_status <= csdq_pkg::ST_ENQ;
                                    r_res_ent    <= '0;
                                    r_state      <= S_DONE;
                                end
                            end
                            default: begin
                                // stale voice beats first voice
                                if (rd_voice && (age_bad || !r_found)) begin
                                    r_sel     <= r_pidx;
                                    r_sel_ent <= rd_ent;
                                end
                                if (rd_voice) r_found <= 1'b1;
                                if ((rd_voice && age_bad) || rd_last) r_state <= S_DEBIT;
                            end
                        endcase
                    end
                end
                S_DEBIT: begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_sel_ent.cls == 2'(k)) r_occ[k] <= deb_val;
                    end
                    r_held_bytes <= r_held_bytes - csdq_pkg::HB_W'(r_sel_ent.bytes);
                    r_ptr        <= csdq_pkg::CW'(r_sel) + csdq_pkg::CW'(1);
                    r_dec        <= 1'b1;
                    r_res_ent    <= r_sel_ent;
                    if (r_mode == M_HEAD) begin
                        r_res_status <= csdq_pkg::ST_DEQ;
                    end else if (csdq_pkg::CW'(r_sel) == r_count - csdq_pkg::CW'(1)) begin
                        r_res_status <= csdq_pkg::ST_IN_DROP;
                    end else begin
                        r_res_status <= csdq_pkg::ST_ENQ_DROP;
                    end
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (!issue && !r_pend) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{status: r_res_status, out_tag: r_res_ent.tag,
                                         out_class: r_res_ent.cls,
                                         out_bytes: r_res_ent.bytes,
                                         queue_count: 7'(final_count)};
                        r_count     <= final_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // the queue never holds more than the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= csdq_pkg::CW'(csdq_pkg::DEPTH))
        else $error("held count beyond store depth");

    // compaction writes stay inside the held range
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && ram_we) |-> (csdq_pkg::CW'(ram_waddr) < r_count))
        else $error("compaction write outside held entries");

    // a finished item lands in the output register
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || i_out_ready)) |=>
        (r_out_valid && r_state == S_IDLE))
        else $error("result not loaded on completion");

    // a new item is taken only with no item in flight
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("item accepted but sequencer stayed idle");

endmodule

FILE: tb/csdq_checker.sv
`timescale 1ns / 1ps

module csdq_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  csdq_pkg::t_in   i_in,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  csdq_pkg::t_out  i_out,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data,
    output int              o_mismatches,
    output int              o_outstanding
);

    // shadow of the descriptor queue and occupancy counters
    csdq_pkg::t_entry slot [csdq_pkg::DEPTH];
    int               held_cnt;
    longint           held_sum;
    int               occ [3];

    // shadow of the configuration registers
    logic [6:0]  lim_reg;
    logic        by_bytes;
    logic [15:0] mean_reg;
    logic [31:0] age_reg;

    csdq_pkg::t_out expected_results [$];
    int             mismatches;

    assign o_mismatches = mismatches;

    function automatic logic [1:0] class_of(logic [15:0] port);
        if (port == csdq_pkg::PORT_FTP_DATA || port == csdq_pkg::PORT_FTP_CTRL)
            return csdq_pkg::CLS_TCP;
        if (port == csdq_pkg::PORT_DNS) return csdq_pkg::CLS_UDP;
        return csdq_pkg::CLS_VOICE;
    endfunction

    // remove one descriptor, debit its class and close the gap
    function automatic void drop_slot(int idx);
        int b;
        b = int'(slot[idx].bytes);
        occ[slot[idx].cls] = (occ[slot[idx].cls] > b) ? occ[slot[idx].cls] - b : 0;
        held_sum -= b;
        for (int i = idx; i + 1 < held_cnt; i++) slot[i] = slot[i + 1];
        held_cnt--;
    endfunction

    // predicted result of one queue operation
    function automatic csdq_pkg::t_out queue_step(csdq_pkg::t_in it);
        csdq_pkg::t_out r;
        logic [1:0]     c;
        int             sel;
        int             last;
        int             want;
        bit             has;
        bit             found;
        bit             at_lim;
        r = '0;
        has = 0;
        found = 0;
        sel = 0;
        if (it.op == csdq_pkg::OP_DEQ) begin
            if (held_cnt == 0) begin
                r.status = csdq_pkg::ST_EMPTY;
            end else begin
                r.status    = csdq_pkg::ST_DEQ;
                r.out_tag   = slot[0].tag;
                r.out_class = slot[0].cls;
                r.out_bytes = slot[0].bytes;
                drop_slot(0);
            end
            r.queue_count = held_cnt[6:0];
            return r;
        end
        c = class_of(it.dest_port);
        // store full: incoming item is refused
        if (held_cnt >= csdq_pkg::DEPTH) begin
            r.status      = csdq_pkg::ST_IN_DROP;
            r.out_tag     = it.pkt_tag;
            r.out_class   = c;
            r.out_bytes   = it.pkt_bytes;
            r.queue_count = held_cnt[6:0];
            return r;
        end
        if (by_bytes)
            at_lim = (held_sum + longint'(it.pkt_bytes)) >=
                     (longint'(lim_reg) * longint'(mean_reg));
        else
            at_lim = (held_cnt + 1) >= int'(lim_reg);
        last = held_cnt;
        slot[last].tag   = it.pkt_tag;
        slot[last].cls   = c;
        slot[last].bytes = it.pkt_bytes;
        slot[last].ptime = it.pkt_time_ms;
        held_cnt++;
        held_sum += longint'(it.pkt_bytes);
        if (at_lim) begin
            occ[c] = (occ[c] + int'(it.pkt_bytes) > int'(csdq_pkg::OCC_MAX))
                     ? int'(csdq_pkg::OCC_MAX) : occ[c] + int'(it.pkt_bytes);
            if (occ[csdq_pkg::CLS_VOICE] > occ[csdq_pkg::CLS_TCP] &&
                occ[csdq_pkg::CLS_VOICE] > occ[csdq_pkg::CLS_UDP]) begin
                if (c == csdq_pkg::CLS_VOICE) begin
                    // oldest stale voice item, else the first voice item
                    for (int i = 0; i < held_cnt; i++) begin
                        if (slot[i].cls == csdq_pkg::CLS_VOICE) begin
                            if (!found) begin
                                found = 1;
                                sel = i;
                            end
                            if (longint'(it.now_ms) - longint'(slot[i].ptime) >
                                longint'(age_reg)) begin
                                sel = i;
                                break;
                            end
                        end
                    end
                    has = 1;
                end else begin
                    sel = last;
                    has = 1;
                end
            end else begin
                want = (occ[csdq_pkg::CLS_TCP] > occ[csdq_pkg::CLS_UDP])
                       ? csdq_pkg::CLS_TCP : csdq_pkg::CLS_UDP;
                for (int i = 0; i < held_cnt; i++) begin
                    if (slot[i].cls == want) begin
                        sel = i;
                        has = 1;
                        break;
                    end
                end
            end
        end
        if (has) begin
            r.status    = (sel == last) ? csdq_pkg::ST_IN_DROP : csdq_pkg::ST_ENQ_DROP;
            r.out_tag   = slot[sel].tag;
            r.out_class = slot[sel].cls;
            r.out_bytes = slot[sel].bytes;
            drop_slot(sel);
        end else begin
            r.status = csdq_pkg::ST_ENQ;
        end
        r.queue_count = held_cnt[6:0];
        return r;
    endfunction

    // watch the channels at every edge
    always @(posedge i_clk) begin
        csdq_pkg::t_out want_r;
        if (!i_rst_n) begin
            held_cnt = 0;
            held_sum = 0;
            occ[0] = 0;
            occ[1] = 0;
            occ[2] = 0;
            lim_reg  = 7'd50;
            by_bytes = 1'b0;
            mean_reg = 16'd500;
            age_reg  = 32'd300;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: got %p", i_out);
                end else begin
                    want_r = expected_results.pop_front();
                    if (i_out.status !== want_r.status || i_out.out_tag !== want_r.out_tag ||
                        i_out.out_class !== want_r.out_class ||
                        i_out.out_bytes !== want_r.out_bytes ||
                        i_out.queue_count !== want_r.queue_count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p got %p", want_r, i_out);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(queue_step(i_in));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    csdq_pkg::CFG_QUEUE_LIMIT: lim_reg  = i_cfg_data[6:0];
                    csdq_pkg::CFG_COUNT_BYTES: by_bytes = i_cfg_data[0];
                    csdq_pkg::CFG_MEAN_BYTES:  mean_reg = i_cfg_data[15:0];
                    csdq_pkg::CFG_MAX_AGE:     age_reg  = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_outstanding = expected_results.size();
    end

    initial mismatches = 0;

endmodule

FILE: tb/tb_class_aware_selective_drop_queue.sv
`timescale 1ns / 1ps

module tb_class_aware_selective_drop_queue;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int NUM_PHASES  = 8;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    csdq_pkg::t_in  in_item = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    csdq_pkg::t_out out_item;
    logic           cfg_we = 1'b0;
    logic [1:0]     cfg_idx = csdq_pkg::CFG_QUEUE_LIMIT;
    logic [31:0]    cfg_data = '0;
    int             mismatches;
    int             outstanding;
    int             cycles = 0;
    bit             calm = 0;
    int             stall_left = 0;
    int             enq_pct = 60;
    int             size_cap = 1500;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    class_aware_selective_drop_queue u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    csdq_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[class_aware_selective_drop_queue] ERROR");
            $finish;
        end
    end

    task automatic send_item(csdq_pkg::t_in it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic write_cfg(int lim, int cb, int mean, logic [31:0] age);
        in_valid <= 1'b0;
        // let the checker log the last accepted item first
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        cfg_we <= 1'b1; cfg_idx <= csdq_pkg::CFG_QUEUE_LIMIT; cfg_data <= lim;
        @(posedge i_clk);
        cfg_idx <= csdq_pkg::CFG_COUNT_BYTES; cfg_data <= cb;
        @(posedge i_clk);
        cfg_idx <= csdq_pkg::CFG_MEAN_BYTES; cfg_data <= mean;
        @(posedge i_clk);
        cfg_idx <= csdq_pkg::CFG_MAX_AGE; cfg_data <= age;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic csdq_pkg::t_in make_pkt(logic op, logic [15:0] tag, logic [15:0] port,
                                               logic [15:0] bytes, logic [31:0] pt,
                                               logic [31:0] now);
        csdq_pkg::t_in it;
        it.op = op;
        it.pkt_tag = tag;
        it.dest_port = port;
        it.pkt_bytes = bytes;
        it.pkt_time_ms = pt;
        it.now_ms = now;
        return it;
    endfunction

    // random packet with class and age spread around the age limit
    function automatic csdq_pkg::t_in random_pkt();
        csdq_pkg::t_in it;
        logic [31:0]   now;
        now = $urandom();
        it.op = ($urandom_range(0, 99) < enq_pct) ? csdq_pkg::OP_ENQ : csdq_pkg::OP_DEQ;
        it.pkt_tag = 16'($urandom());
        case ($urandom_range(0, 3))
            0: it.dest_port = csdq_pkg::PORT_FTP_DATA;
            1: it.dest_port = csdq_pkg::PORT_FTP_CTRL;
            2: it.dest_port = csdq_pkg::PORT_DNS;
            default: it.dest_port = 16'($urandom());
        endcase
        it.pkt_bytes = ($urandom_range(0, 19) == 0) ? 16'($urandom()) :
                       16'($urandom_range(0, size_cap));
        case ($urandom_range(0, 4))
            0: it.pkt_time_ms = $urandom();
            1: it.pkt_time_ms = now + $urandom_range(0, 500);
            default: it.pkt_time_ms = now - $urandom_range(0, 1200);
        endcase
        it.now_ms = now;
        return it;
    endfunction

    initial begin
        int          lims  [NUM_PHASES] = '{3, 1, 64, 64, 8, 1, 16, 5};
        int          cbs   [NUM_PHASES] = '{0, 0, 0, 1, 1, 1, 0, 1};
        int          means [NUM_PHASES] = '{500, 500, 1, 65535, 500, 1, 65535, 300};
        logic [31:0] ages  [NUM_PHASES] = '{300, 0, 32'hFFFF_FFFF, 300, 1000, 200, 0, 300};
        int          pcts  [NUM_PHASES] = '{60, 55, 70, 92, 65, 60, 60, 65};
        int          caps  [NUM_PHASES] = '{1500, 1500, 1500, 200, 1000, 1500, 65535, 600};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults first, then a tight limit
        send_item(make_pkt(csdq_pkg::OP_DEQ, 16'h0000, 16'd0, 16'd0, 32'd0, 32'd0));
        send_item(make_pkt(csdq_pkg::OP_ENQ, 16'h0000, csdq_pkg::PORT_FTP_DATA, 16'd0,
                           32'd0, 32'd0));
        send_item(make_pkt(csdq_pkg::OP_DEQ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF));
        send_item(make_pkt(csdq_pkg::OP_DEQ, 16'h0001, 16'd0, 16'd0, 32'd0, 32'd0));
        write_cfg(3, 0, 500, 300);
        send_item(make_pkt(csdq_pkg::OP_ENQ, 16'hFFFF, csdq_pkg::PORT_FTP_CTRL, 16'hFFFF,
                           32'd0, 32'd100));
        send_item(make_pkt(csdq_pkg::OP_ENQ, 16'h0011, csdq_pkg::PORT_DNS, 16'd100,
                           32'd0, 32'd100));
        send_item(make_pkt(csdq_pkg::OP_ENQ, 16'h0012, csdq_pkg::PORT_DNS, 16'd200,
                           32'd0, 32'd100));
        send_item(make_pkt(csdq_pkg::OP_ENQ, 16'h0013, 16'hFFFF, 16'd9000, 32'd0, 32'd100));
        send_item(make_pkt(csdq_pkg::OP_ENQ, 16'h0014, 16'd0, 16'd60000, 32'd5, 32'd1000));
        send_item(make_pkt(csdq_pkg::OP_ENQ, 16'h0015, 16'd80, 16'd500, 32'hFFFF_FFFF,
                           32'd1000));
        send_item(make_pkt(csdq_pkg::OP_ENQ, 16'h0016, csdq_pkg::PORT_FTP_DATA, 16'd1,
                           32'd0, 32'd1000));
        send_item(make_pkt(csdq_pkg::OP_ENQ, 16'h0017, 16'd5060, 16'd40, 32'd0,
                           32'hFFFF_FFFF));
        send_item(make_pkt(csdq_pkg::OP_DEQ, 16'h0000, 16'd0, 16'd0, 32'd0, 32'd0));
        send_item(make_pkt(csdq_pkg::OP_DEQ, 16'h0000, 16'd0, 16'd0, 32'd0, 32'd0));
        send_item(make_pkt(csdq_pkg::OP_DEQ, 16'h0000, 16'd0, 16'd0, 32'd0, 32'd0));
        send_item(make_pkt(csdq_pkg::OP_DEQ, 16'h0000, 16'd0, 16'd0, 32'd0, 32'd0));

        // random phases across the register settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_cfg(lims[p], cbs[p], means[p], ages[p]);
            calm     = (p % 3 == 2);
            enq_pct  = pcts[p];
            size_cap = caps[p];
            for (int n = 0; n < 250; n++) send_item(random_pkt());
        end
        in_valid <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0)
            $display("[class_aware_selective_drop_queue] OK");
        else
            $display("[class_aware_selective_drop_queue] ERROR");
        $finish;
    end

endmodule
